FILE: hdl/amsd_pkg.sv
package amsd_pkg;

	localparam int FORCE_W  = 24;
	localparam int POS_W    = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int WIDE_W   = 64;
	localparam int REM_W    = 60;
	localparam int STEP_W   = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_NATURAL_FREQ  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_RATIO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd3;

	localparam logic [23:0] RST_NATURAL_FREQ  = 24'd2560;
	localparam logic [15:0] RST_DAMPING_RATIO = 16'd4096;
	localparam logic [31:0] RST_STIFFNESS     = 32'd256000;
	localparam logic [23:0] RST_SAMPLE_PERIOD = 24'd16777;

	localparam logic [STEP_W-1:0] G_STEPS  = 7'd32;
	localparam logic [STEP_W-1:0] B_STEPS  = 7'd30;
	localparam logic [STEP_W-1:0] B2_STEPS = 7'd32;
	localparam logic [STEP_W-1:0] T_STEPS  = 7'd59;

	typedef struct packed {
		logic              start;
		logic [WIDE_W-1:0] a;
		logic [WIDE_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              start;
		logic              frac;
		logic [REM_W-1:0]  r_init;
		logic [WIDE_W-1:0] dvd;
		logic [REM_W-1:0]  d;
		logic [STEP_W-1:0] steps;
	} div_req_t;

endpackage

FILE: hdl/amsd_mul.sv
module amsd_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  amsd_pkg::mul_req_t                req,
	output logic                              done,
	output logic [amsd_pkg::WIDE_W-1:0]       prod
);

	logic                          busy_q;
	logic [amsd_pkg::WIDE_W-1:0]   acc_q;
	logic [amsd_pkg::WIDE_W-1:0]   a_q;
	logic [amsd_pkg::WIDE_W-1:0]   b_q;

	assign done = busy_q && (b_q == '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (b_q == '0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[amsd_pkg::WIDE_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[amsd_pkg::WIDE_W-1:1]};
		end
	end

endmodule

FILE: hdl/amsd_div.sv
module amsd_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  amsd_pkg::div_req_t                req,
	output logic                              done,
	output logic [amsd_pkg::WIDE_W-1:0]       quo
);

	logic                          busy_q;
	logic                          pre_q;
	logic [amsd_pkg::STEP_W-1:0]   cnt_q;
	logic [amsd_pkg::REM_W-1:0]    r_q;
	logic [amsd_pkg::REM_W-1:0]    d_q;
	logic [amsd_pkg::WIDE_W-1:0]   dvd_q;
	logic [amsd_pkg::WIDE_W-1:0]   q_q;
	logic [amsd_pkg::REM_W-1:0]    rs;

	assign done = busy_q && !pre_q && (cnt_q == '0);
	assign quo  = q_q;
	assign rs   = {r_q[amsd_pkg::REM_W-2:0], dvd_q[amsd_pkg::WIDE_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q   <= req.r_init;
			d_q   <= req.d;
			dvd_q <= req.dvd;
			q_q   <= '0;
			cnt_q <= req.steps;
			pre_q <= req.frac;
		end else if (busy_q) begin
			if (pre_q) begin
				pre_q <= 1'b0;
				if (r_q >= d_q) begin
					r_q <= r_q - d_q;
					q_q <= {{(amsd_pkg::WIDE_W-1){1'b0}}, 1'b1};
				end
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				dvd_q <= {dvd_q[amsd_pkg::WIDE_W-2:0], 1'b0};
				if (rs >= d_q) begin
					r_q <= rs - d_q;
					q_q <= {q_q[amsd_pkg::WIDE_W-2:0], 1'b1};
				end else begin
					r_q <= rs;
					q_q <= {q_q[amsd_pkg::WIDE_W-2:0], 1'b0};
				end
			end
		end
	end

endmodule

FILE: hdl/admittance_filter_msd_tustin.sv
// Result timing is set by the bit-serial multiplier (one multiplier bit per cycle)
// and the restoring divider of up to 59 steps.
// After reset or any configuration write the next item with nonzero stiffness first
// rebuilds the filter coefficients: three products and three divisions.
// Items do not overlap: a new item is taken only when idle; one is taken while a result waits.
// Reset (arst_n low): registers take their documented values, histories clear.
module admittance_filter_msd_tustin (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [amsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [amsd_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [23:0]              ext_force,
	input  logic signed [31:0]              ref_position,
	input  logic                            adjust_enable,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [31:0]              position_offset,
	output logic signed [31:0]              adjusted_ref,
	output logic                            div_fault
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_WT, ST_WT_W, ST_XX, ST_XX_W, ST_ZX, ST_ZX_W, ST_POLY,
		ST_G, ST_G_W, ST_B2, ST_B2_W, ST_B3, ST_B3_W,
		ST_GS, ST_GS_W, ST_T, ST_T_W, ST_M2, ST_M2_W, ST_M3, ST_M3_W,
		ST_ACC, ST_FIN
	} state_t;

	state_t state_q;

	logic [23:0] wn_q;
	logic [15:0] zeta_q;
	logic [31:0] k_q;
	logic [23:0] ts_q;
	logic        dirty_q;

	logic signed [23:0] f1_q, f2_q, f_q;
	logic signed [31:0] d1_q, d2_q, ref_q;
	logic               en_q, fault_q, s_neg_q;

	logic [31:0]        xq_q;
	logic [55:0]        x2_q;
	logic [53:0]        zx4_q;
	logic [57:0]        p1_q;
	logic signed [58:0] p2_q, p3_q;
	logic [31:0]        g_q;
	logic signed [31:0] b2_q, b3_q;
	logic [58:0]        gs_q;
	logic signed [63:0] t_q, fs1_q, fs2_q, acc_q;

	logic               out_valid_q;
	logic signed [31:0] offset_q, adj_q;
	logic               fault_out_q;

	amsd_pkg::mul_req_t mreq;
	amsd_pkg::div_req_t dreq;
	logic               m_done, d_done;
	logic [63:0]        m_prod, d_quo;

	amsd_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .done(m_done), .prod(m_prod));
	amsd_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(d_done), .quo(d_quo));

	logic signed [26:0] s_sum;
	logic [26:0]        s_mag;
	logic [57:0]        p2_mag, p3_mag;
	logic [31:0]        b2_mag, b3_mag, d1_mag, d2_mag;
	logic [48:0]        x_rnd;
	logic [63:0]        m_signed;
	logic signed [63:0] acc_rnd, acc_sh;
	logic signed [31:0] off_sat, off_val, adj_val;
	logic signed [32:0] adj_sum;
	logic               out_free;

	assign s_sum = 27'(f_q) + 27'(signed'({f1_q, 1'b0})) + 27'(f2_q);
	assign s_mag = s_sum[26] ? 27'(-s_sum) : 27'(s_sum);
	assign p2_mag = p2_q[58] ? 58'(-p2_q) : p2_q[57:0];
	assign p3_mag = p3_q[58] ? 58'(-p3_q) : p3_q[57:0];
	assign b2_mag = b2_q[31] ? 32'(-b2_q) : 32'(b2_q);
	assign b3_mag = b3_q[31] ? 32'(-b3_q) : 32'(b3_q);
	assign d1_mag = d1_q[31] ? 32'(-d1_q) : 32'(d1_q);
	assign d2_mag = d2_q[31] ? 32'(-d2_q) : 32'(d2_q);
	assign x_rnd  = {1'b0, m_prod[47:0]} + 49'd128;

	always_comb begin
		m_signed = m_prod;
		if (state_q == ST_M2_W && (b2_q[31] ^ d1_q[31])) begin
			m_signed = -m_prod;
		end else if (state_q == ST_M3_W && (b3_q[31] ^ d2_q[31])) begin
			m_signed = -m_prod;
		end
	end

	assign acc_rnd = acc_q + 64'sd128;
	assign acc_sh  = acc_rnd >>> 8;
	assign off_sat = (acc_sh[63:31] == '0 || acc_sh[63:31] == '1) ? acc_sh[31:0] :
		(acc_sh[63] ? 32'sh80000000 : 32'sh7fffffff);
	assign off_val = fault_q ? 32'sd0 : off_sat;
	assign adj_sum = 33'(ref_q) + 33'(off_val);
	assign adj_val = !en_q ? ref_q : ((adj_sum[32] == adj_sum[31]) ? adj_sum[31:0] :
		(adj_sum[32] ? 32'sh80000000 : 32'sh7fffffff));
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_WT: begin
				mreq.start = 1'b1;
				mreq.a = 64'(wn_q);
				mreq.b = 64'(ts_q);
			end
			ST_XX: begin
				mreq.start = 1'b1;
				mreq.a = 64'(xq_q);
				mreq.b = 64'(xq_q);
			end
			ST_ZX: begin
				mreq.start = 1'b1;
				mreq.a = 64'(zeta_q);
				mreq.b = 64'(xq_q);
			end
			ST_GS: begin
				mreq.start = 1'b1;
				mreq.a = 64'(g_q);
				mreq.b = 64'(s_mag);
			end
			ST_M2: begin
				mreq.start = 1'b1;
				mreq.a = 64'(b2_mag);
				mreq.b = 64'(d1_mag);
			end
			ST_M3: begin
				mreq.start = 1'b1;
				mreq.a = 64'(b3_mag);
				mreq.b = 64'(d2_mag);
			end
			default: mreq = '0;
		endcase
	end

	always_comb begin
		dreq = '0;
		unique case (state_q)
			ST_G: begin
				dreq.start = 1'b1;
				dreq.frac = 1'b1;
				dreq.r_init = 60'(x2_q);
				dreq.d = 60'(p1_q);
				dreq.steps = amsd_pkg::G_STEPS;
			end
			ST_B2: begin
				dreq.start = 1'b1;
				dreq.frac = 1'b0;
				dreq.r_init = 60'(p2_mag >> 2);
				dreq.dvd = {p2_mag[1:0], 62'b0};
				dreq.d = 60'(p1_q);
				dreq.steps = amsd_pkg::B2_STEPS;
			end
			ST_B3: begin
				dreq.start = 1'b1;
				dreq.frac = 1'b1;
				dreq.r_init = 60'(p3_mag);
				dreq.d = 60'(p1_q);
				dreq.steps = amsd_pkg::B_STEPS;
			end
			ST_T: begin
				dreq.start = 1'b1;
				dreq.frac = 1'b0;
				dreq.dvd = {gs_q, 5'b0};
				dreq.d = 60'(k_q);
				dreq.steps = amsd_pkg::T_STEPS;
			end
			default: dreq = '0;
		endcase
	end

	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign position_offset = offset_q;
	assign adjusted_ref    = adj_q;
	assign div_fault       = fault_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wn_q        <= amsd_pkg::RST_NATURAL_FREQ;
			zeta_q      <= amsd_pkg::RST_DAMPING_RATIO;
			k_q         <= amsd_pkg::RST_STIFFNESS;
			ts_q        <= amsd_pkg::RST_SAMPLE_PERIOD;
			dirty_q     <= 1'b1;
			f1_q        <= '0;
			f2_q        <= '0;
			d1_q        <= '0;
			d2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				dirty_q <= 1'b1;
				unique case (cfg_index)
					amsd_pkg::CFG_NATURAL_FREQ:  wn_q   <= cfg_data[23:0];
					amsd_pkg::CFG_DAMPING_RATIO: zeta_q <= cfg_data[15:0];
					amsd_pkg::CFG_STIFFNESS:     k_q    <= cfg_data;
					amsd_pkg::CFG_SAMPLE_PERIOD: ts_q   <= cfg_data[23:0];
					default: ;
				endcase
			end else if (state_q == ST_B3_W && d_done) begin
				dirty_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						f_q     <= ext_force;
						ref_q   <= ref_position;
						en_q    <= adjust_enable;
						fault_q <= (k_q == '0);
						acc_q   <= '0;
						if (k_q == '0) begin
							state_q <= ST_FIN;
						end else if (dirty_q) begin
							state_q <= ST_WT;
						end else begin
							state_q <= ST_GS;
						end
					end
				end
				ST_WT:   state_q <= ST_WT_W;
				ST_WT_W: begin
					if (m_done) begin
						xq_q    <= (x_rnd[48:40] != '0) ? 32'hffffffff : x_rnd[39:8];
						state_q <= ST_XX;
					end
				end
				ST_XX:   state_q <= ST_XX_W;
				ST_XX_W: begin
					if (m_done) begin
						x2_q    <= m_prod[63:8];
						state_q <= ST_ZX;
					end
				end
				ST_ZX:   state_q <= ST_ZX_W;
				ST_ZX_W: begin
					if (m_done) begin
						zx4_q   <= {m_prod[47:0], 6'b0};
						state_q <= ST_POLY;
					end
				end
				ST_POLY: begin
					p1_q    <= (58'd1 << 42) + 58'(zx4_q) + 58'(x2_q);
					p2_q    <= signed'({2'b0, x2_q, 1'b0}) - (59'sd1 <<< 43);
					p3_q    <= (59'sd1 <<< 42) + signed'({3'b0, x2_q}) -
						signed'({5'b0, zx4_q});
					state_q <= ST_G;
				end
				ST_G:    state_q <= ST_G_W;
				ST_G_W: begin
					if (d_done) begin
						g_q     <= d_quo[31:0];
						state_q <= ST_B2;
					end
				end
				ST_B2:   state_q <= ST_B2_W;
				ST_B2_W: begin
					if (d_done) begin
						b2_q    <= p2_q[58] ? -signed'(d_quo[31:0]) : signed'(d_quo[31:0]);
						state_q <= ST_B3;
					end
				end
				ST_B3:   state_q <= ST_B3_W;
				ST_B3_W: begin
					if (d_done) begin
						b3_q    <= p3_q[58] ? -signed'(d_quo[31:0]) : signed'(d_quo[31:0]);
						state_q <= ST_GS;
					end
				end
				ST_GS: begin
					s_neg_q <= s_sum[26];
					state_q <= ST_GS_W;
				end
				ST_GS_W: begin
					if (m_done) begin
						gs_q    <= m_prod[58:0];
						state_q <= ST_T;
					end
				end
				ST_T:    state_q <= ST_T_W;
				ST_T_W: begin
					if (d_done) begin
						t_q     <= s_neg_q ? -signed'({5'b0, d_quo[58:0]}) :
							signed'({5'b0, d_quo[58:0]});
						state_q <= ST_M2;
					end
				end
				ST_M2:   state_q <= ST_M2_W;
				ST_M2_W: begin
					if (m_done) begin
						fs1_q   <= signed'(m_signed) >>> 22;
						state_q <= ST_M3;
					end
				end
				ST_M3:   state_q <= ST_M3_W;
				ST_M3_W: begin
					if (m_done) begin
						fs2_q   <= signed'(m_signed) >>> 22;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					acc_q   <= t_q - fs1_q - fs2_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						offset_q    <= off_val;
						adj_q       <= adj_val;
						fault_out_q <= fault_q;
						f2_q        <= f1_q;
						f1_q        <= f_q;
						d2_q        <= d1_q;
						d1_q        <= off_val;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
